// ===== design/trs_pkg.sv =====
`default_nettype none
package trs_pkg;
   localparam int COUNT_BITS_DEFAULT = 20;
   localparam int WORD_W = 20;
   localparam int SYL_W = 24;
   localparam int SCORE_W = 16;
   // Numerator width: 206835*W*S with W,S < 2^24 stays below 2^66.
   localparam int NUM_W = 72;
   localparam int DIV_STEPS = NUM_W;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_NO_WORDS = 2'd1,
      STATUS_NO_SENTENCES = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_SCAN, ST_MUL_WS, ST_MUL_WW, ST_MUL_YS, ST_NUM_EASE, ST_ABS_EASE, ST_DIV_EASE,
      ST_NUM_GRADE, ST_ABS_GRADE, ST_DIV_GRADE, ST_EMIT
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic load_ws;
      logic load_ww;
      logic load_ys;
      logic build_ease;
      logic build_grade;
      logic load_quo;
      logic div_step;
      logic store_ease;
      logic clear_all;
   } cmd_type;

   typedef struct packed {
      logic final_done;
      logic no_words;
      logic no_sentences;
      logic div_last;
   } stat_type;

   function automatic logic is_vowel(input logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return l == "a" || l == "e" || l == "i" || l == "o" || l == "u" || l == "y";
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction
endpackage
`default_nettype wire

// ===== design/trs_if.sv =====
`default_nettype none
interface trs_req_if;
   logic valid;
   logic ready;
   logic [7:0] text_byte;
   logic end_of_text;
   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface trs_rsp_if;
   logic valid;
   logic ready;
   logic [19:0] word_total;
   logic [19:0] sentence_total;
   logic [23:0] syllable_total;
   logic signed [15:0] reading_ease;
   logic signed [15:0] grade_tenths;
   logic [1:0] score_status;
   modport source (output valid, word_total, sentence_total, syllable_total,
      reading_ease, grade_tenths, score_status, input ready);
   modport sink (input valid, word_total, sentence_total, syllable_total,
      reading_ease, grade_tenths, score_status, output ready);
endinterface
`default_nettype wire

// ===== design/text_readability_scorer.sv =====
`default_nettype none
// Readability scorer. Text bytes transfer in one per cycle while no final result
// is pending; whitespace splits tokens, tokens with digits are dropped, and the
// word, sentence and syllable counts build up. The byte marked end_of_text closes
// the text; the block then runs three multiplies and two 72-step restoring
// divisions (one quotient bit per cycle) that give the Flesch reading ease and
// the Kincaid grade in tenths, rounded half away from zero and saturated to 16
// bits. The result transfer then clears all counts for the next text. With no
// words or no sentences the result follows at once with zero scores.
module text_readability_scorer
   import trs_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   trs_req_if.sink req,
   trs_rsp_if.source rsp
);
   cmd_type cmd;
   stat_type stat;

   trs_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .cmd(cmd)
   );

   trs_datapath #(.COUNT_BITS(COUNT_BITS)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .text_byte(req.text_byte), .end_of_text(req.end_of_text),
      .word_total(rsp.word_total), .sentence_total(rsp.sentence_total),
      .syllable_total(rsp.syllable_total), .reading_ease(rsp.reading_ease),
      .grade_tenths(rsp.grade_tenths), .score_status(rsp.score_status)
   );
endmodule
`default_nettype wire

// ===== design/trs_datapath.sv =====
`default_nettype none
module trs_datapath
   import trs_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire cmd_type cmd,
   output stat_type stat,
   input wire logic [7:0] text_byte,
   input wire logic end_of_text,
   output logic [WORD_W-1:0] word_total,
   output logic [WORD_W-1:0] sentence_total,
   output logic [SYL_W-1:0] syllable_total,
   output logic signed [SCORE_W-1:0] reading_ease,
   output logic signed [SCORE_W-1:0] grade_tenths,
   output logic [1:0] score_status
);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   logic [COUNT_BITS-1:0] words_ff, words_in, sents_ff, sents_in;
   logic [SYL_W-1:0] syl_ff, syl_in;
   logic inside_ff, inside_in, digit_ff, digit_in, pend_ff, pend_in;
   logic [7:0] last_ff, last_in, r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in, wsyl_ff, wsyl_in;
   logic [2:0] lv_ff, lv_in;
   logic done_ff;

   // Token scan, one byte per cycle while take_byte is asserted.
   always_comb begin
      logic close;
      logic [8:0] ws;
      logic [SYL_W:0] sum;
      logic skip;
      words_in = words_ff; sents_in = sents_ff; syl_in = syl_ff;
      inside_in = inside_ff; digit_in = digit_ff; pend_in = pend_ff;
      last_in = last_ff; r0_in = r0_ff; r1_in = r1_ff; r2_in = r2_ff;
      wsyl_in = wsyl_ff; lv_in = lv_ff;
      close = 1'b0;
      ws = '0; sum = '0; skip = 1'b0;
      if (is_space(text_byte)) begin
         close = 1'b1;
      end else begin
         inside_in = 1'b1;
         last_in = text_byte;
         if (text_byte >= "0" && text_byte <= "9") digit_in = 1'b1;
         if (is_letter(text_byte)) begin
            if (lv_ff[0] && !pend_ff && is_vowel(r0_ff)) begin
               if (wsyl_ff != 8'hFF) wsyl_in = wsyl_ff + 8'd1;
               skip = is_vowel(text_byte);
            end
            r2_in = r1_ff; r1_in = r0_ff; r0_in = text_byte;
            lv_in = {lv_ff[1:0], 1'b1};
            pend_in = skip;
         end
      end
      if (end_of_text) close = 1'b1;
      if (close && inside_in && !digit_in) begin
         if (words_ff != CMAX) words_in = words_ff + 1'b1;
         if (last_in == "." || last_in == ":" || last_in == ";" || last_in == "?" ||
             last_in == "!") begin
            if (sents_ff != CMAX) sents_in = sents_ff + 1'b1;
         end
         ws = {1'b0, wsyl_in};
         if (lv_in[0] && !pend_in && is_vowel(r0_in)) begin
            if ((r0_in | 8'h20) == "e") begin
               if (lv_in[1] && (r1_in | 8'h20) == "l" && (!lv_in[2] || !is_vowel(r2_in)))
                  ws = ws + 9'd1;
            end else begin
               ws = ws + 9'd1;
            end
         end
         if (ws == '0) ws = 9'd1;
         sum = {1'b0, syl_ff} + {{(SYL_W-8){1'b0}}, ws};
         syl_in = sum[SYL_W] ? '1 : sum[SYL_W-1:0];
      end
      if (close) begin
         inside_in = 1'b0; digit_in = 1'b0; pend_in = 1'b0; last_in = '0;
         lv_in = '0; wsyl_in = '0; r0_in = '0; r1_in = '0; r2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         words_ff <= '0; sents_ff <= '0; syl_ff <= '0;
         inside_ff <= 1'b0; digit_ff <= 1'b0; pend_ff <= 1'b0; last_ff <= '0;
         r0_ff <= '0; r1_ff <= '0; r2_ff <= '0; wsyl_ff <= '0; lv_ff <= '0;
         done_ff <= 1'b0;
      end else if (cmd.take_byte) begin
         words_ff <= words_in; sents_ff <= sents_in; syl_ff <= syl_in;
         inside_ff <= inside_in; digit_ff <= digit_in; pend_ff <= pend_in;
         last_ff <= last_in; r0_ff <= r0_in; r1_ff <= r1_in; r2_ff <= r2_in;
         wsyl_ff <= wsyl_in; lv_ff <= lv_in;
         done_ff <= end_of_text;
      end else begin
         done_ff <= 1'b0;
      end
   end

   // Score arithmetic: products, a registered numerator, then restoring division.
   logic [47:0] ws_ff, ww_ff, ys_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] rem_ff, quo_ff, den_ff;
   logic neg_ff;
   logic [6:0] step_ff;
   logic signed [SCORE_W-1:0] ease_ff;
   logic [47:0] w48, s48, y48;
   assign w48 = 48'(words_ff);
   assign s48 = 48'(sents_ff);
   assign y48 = 48'(syl_ff);

   logic signed [NUM_W-1:0] ease_num, grade_num, num_abs;
   logic [NUM_W:0] trial;
   logic [NUM_W-1:0] quo_next, rem_sh;
   logic signed [NUM_W+1:0] rq;
   logic signed [SCORE_W-1:0] sat_q;

   // ease*1000WS = 206835WS - 84600YS - 1015WW, rounded by adding WS*500.
   assign ease_num = NUM_W'(206835) * $signed({24'd0, ws_ff})
      - NUM_W'(84600) * $signed({24'd0, ys_ff})
      - NUM_W'(1015) * $signed({24'd0, ww_ff});
   // grade_tenths*10WS = 1180YS + 39WW - 1559WS, rounded by adding WS*5.
   assign grade_num = NUM_W'(1180) * $signed({24'd0, ys_ff})
      + NUM_W'(39) * $signed({24'd0, ww_ff})
      - NUM_W'(1559) * $signed({24'd0, ws_ff});

   assign num_abs = num_ff[NUM_W-1] ? -num_ff : num_ff;

   always_comb begin
      rem_sh = {rem_ff[NUM_W-2:0], quo_ff[NUM_W-1]};
      trial = {1'b0, rem_sh} - {1'b0, den_ff};
      quo_next = {quo_ff[NUM_W-2:0], !trial[NUM_W]};
      rq = neg_ff ? -$signed({2'b00, quo_next}) : $signed({2'b00, quo_next});
      if (rq > 32767) sat_q = 16'sh7FFF;
      else if (rq < -32768) sat_q = -16'sh8000;
      else sat_q = SCORE_W'(rq);
   end

   logic signed [SCORE_W-1:0] grade_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_ws) ws_ff <= w48 * s48;
      if (cmd.load_ww) ww_ff <= w48 * w48;
      if (cmd.load_ys) ys_ff <= y48 * s48;
      if (cmd.build_ease || cmd.build_grade) begin
         num_ff <= cmd.build_ease ? ease_num : grade_num;
         den_ff <= cmd.build_ease ? NUM_W'(1000) * {24'd0, ws_ff}
                                  : NUM_W'(10) * {24'd0, ws_ff};
      end
      if (cmd.load_quo) begin
         // |num| + den/2 then floor; den is even so half is exact.
         quo_ff <= num_abs + {1'b0, den_ff[NUM_W-1:1]};
         neg_ff <= num_ff[NUM_W-1];
         rem_ff <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial[NUM_W] ? rem_sh : trial[NUM_W-1:0];
         quo_ff <= quo_next;
         step_ff <= step_ff + 7'd1;
      end
      if (cmd.div_step && stat.div_last) begin
         if (cmd.store_ease) ease_ff <= sat_q;
         else grade_ff <= sat_q;
      end
   end

   assign stat = '{
      final_done: done_ff,
      no_words: (words_ff == '0),
      no_sentences: (sents_ff == '0),
      div_last: (step_ff == 7'(DIV_STEPS - 1))
   };

   assign word_total = WORD_W'(words_ff);
   assign sentence_total = WORD_W'(sents_ff);
   assign syllable_total = syl_ff;
   assign score_status = stat.no_words ? STATUS_NO_WORDS :
                         stat.no_sentences ? STATUS_NO_SENTENCES : STATUS_OK;
   assign reading_ease = (score_status == STATUS_OK) ? ease_ff : '0;
   assign grade_tenths = (score_status == STATUS_OK) ? grade_ff : '0;
endmodule
`default_nettype wire

// ===== design/trs_control.sv =====
`default_nettype none
module trs_control
   import trs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input wire logic rsp_ready,
   input wire stat_type stat,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_SCAN;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SCAN: if (stat.final_done) begin
            state_in = (stat.no_words || stat.no_sentences) ? ST_EMIT : ST_MUL_WS;
         end
         ST_MUL_WS: state_in = ST_MUL_WW;
         ST_MUL_WW: state_in = ST_MUL_YS;
         ST_MUL_YS: state_in = ST_NUM_EASE;
         ST_NUM_EASE: state_in = ST_ABS_EASE;
         ST_ABS_EASE: state_in = ST_DIV_EASE;
         ST_DIV_EASE: if (stat.div_last) state_in = ST_NUM_GRADE;
         ST_NUM_GRADE: state_in = ST_ABS_GRADE;
         ST_ABS_GRADE: state_in = ST_DIV_GRADE;
         ST_DIV_GRADE: if (stat.div_last) state_in = ST_EMIT;
         ST_EMIT: if (rsp_ready) state_in = ST_SCAN;
         default: state_in = ST_SCAN;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_SCAN: begin
            req_ready = !stat.final_done;
            cmd.take_byte = req_valid && !stat.final_done;
         end
         ST_MUL_WS: cmd.load_ws = 1'b1;
         ST_MUL_WW: cmd.load_ww = 1'b1;
         ST_MUL_YS: cmd.load_ys = 1'b1;
         ST_NUM_EASE: cmd.build_ease = 1'b1;
         ST_ABS_EASE: cmd.load_quo = 1'b1;
         ST_DIV_EASE: begin
            cmd.div_step = 1'b1;
            cmd.store_ease = 1'b1;
         end
         ST_NUM_GRADE: cmd.build_grade = 1'b1;
         ST_ABS_GRADE: cmd.load_quo = 1'b1;
         ST_DIV_GRADE: cmd.div_step = 1'b1;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.clear_all = rsp_ready;
         end
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire
